FILE: hdl/tcis_pkg.sv
// Shared types and constants for the tiny CPU instruction step block.
`default_nettype none

package tcis_pkg;

	// Field widths fixed by the instruction format
	localparam int unsigned WORD_W    = 24;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned REG_SEL_W = 5;
	localparam int unsigned REG_SEL_N = 1 << REG_SEL_W;
	localparam int unsigned ADDR_N    = 1 << BYTE_W;

	typedef enum logic [BYTE_W-1:0] {
		OPC_NOP = 8'h00,
		OPC_LDI = 8'h01,
		OPC_MOV = 8'h02,
		OPC_OUT = 8'h03,
		OPC_IN  = 8'h04,
		OPC_JMP = 8'h16
	} opcode_t;

	typedef struct packed {
		logic [WORD_W-1:0] instr_word;
	} instr_t;

	typedef struct packed {
		logic [BYTE_W-1:0]    next_pc;
		logic                 reg_written;
		logic [REG_SEL_W-1:0] reg_index;
		logic [BYTE_W-1:0]    reg_value;
		logic                 io_write;
		logic [BYTE_W-1:0]    io_address;
		logic [BYTE_W-1:0]    io_data;
		logic                 fault_reset;
	} result_t;

endpackage

`default_nettype wire

FILE: hdl/tcis_chan_if.sv
// Valid/ready channel interface carrying one payload per transfer.
`default_nettype none

interface tcis_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/tiny_cpu_instruction_step_top.sv
// Tiny CPU instruction step: top level with execute stage and output register.
//
// instr (sink) takes one 24-bit instruction word per transfer: the word
// fetched at the next_pc of the previous result (0 after reset).
// result (source) gives one result per instruction: next fetch address,
// the register or data memory write it made, and the fault flag.
// Register file and data memory are synchronous memories read at the
// input transfer; the execute stage uses the read data in the next cycle
// and writes back when its result moves into the output register.
// A write back that lands on the same edge as the next read is forwarded.
// Flow: an accepted instruction is registered in the execute stage, then its result in the output register.
// Throughput: one instruction per cycle while result is taken, set by the
// single read-modify-write pass through each memory port.
// Stall: one instruction waits in execute, one in the output register;
// instr.ready then drops until result takes a transfer.
// Reset: program counter zero, all register and data valid bits cleared,
// so every register and data byte reads zero. An unknown opcode does the
// same in its write-back cycle and reports fault_reset.
`default_nettype none

module tiny_cpu_instruction_step_top import tcis_pkg::*; #(
	parameter int unsigned REG_COUNT  = 32,
	parameter int unsigned DATA_DEPTH = 256
) (
	input wire logic     clk,
	input wire logic     arst_n,
	tcis_chan_if.sink    instr,
	tcis_chan_if.source  result
);

	localparam int unsigned RIDX_W = $clog2(REG_COUNT);
	localparam int unsigned AW     = $clog2(DATA_DEPTH);

	// Constant index tables: register select and data address select
	logic [RIDX_W-1:0] reg_map  [REG_SEL_N];
	logic [AW-1:0]     addr_map [ADDR_N];

	for (genvar i = 0; i < REG_SEL_N; i++) begin : g_reg_map
		assign reg_map[i] = RIDX_W'(i % REG_COUNT);
	end
	for (genvar i = 0; i < ADDR_N; i++) begin : g_addr_map
		assign addr_map[i] = AW'(i % DATA_DEPTH);
	end

	// Input decode
	logic [BYTE_W-1:0] in_op2;
	logic [RIDX_W-1:0] in_src;
	logic [AW-1:0]     in_dadr;
	logic              accept;
	logic              commit;

	assign in_op2  = instr.data.instr_word[BYTE_W-1:0];
	assign in_src  = reg_map[in_op2[REG_SEL_W-1:0]];
	assign in_dadr = addr_map[in_op2];

	// Execute stage and output registers
	logic              vld_s1;
	logic [BYTE_W-1:0] opc_s1;
	logic [BYTE_W-1:0] op1_s1;
	logic [BYTE_W-1:0] op2_s1;
	logic [RIDX_W-1:0] src_s1;
	logic [AW-1:0]     dadr_s1;
	logic              rfwd_s1;
	logic [BYTE_W-1:0] rfwd_val_s1;
	logic              dfwd_s1;
	logic [BYTE_W-1:0] dfwd_val_s1;
	logic [BYTE_W-1:0] pc_q;
	logic              out_vld_q;
	result_t           out_q;

	// Memory ports
	logic [BYTE_W-1:0] rf_rd_data;
	logic              rf_chk_valid;
	logic              rf_we;
	logic [RIDX_W-1:0] rf_dst;
	logic [BYTE_W-1:0] rf_wval;
	logic [BYTE_W-1:0] dm_rd_data;
	logic              dm_chk_valid;
	logic              dm_we;
	logic [AW-1:0]     dm_adr;
	logic              fault;
	logic [BYTE_W-1:0] reg_rd;
	logic [BYTE_W-1:0] dat_rd;
	result_t           res;

	assign commit      = vld_s1 && (!out_vld_q || result.ready);
	assign instr.ready = !vld_s1 || commit;
	assign accept      = instr.valid && instr.ready;

	tcis_store #(.DEPTH(REG_COUNT)) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr   (in_src),
		.rd_data   (rf_rd_data),
		.chk_addr  (src_s1),
		.chk_valid (rf_chk_valid),
		.wr_en     (commit && rf_we),
		.wr_addr   (rf_dst),
		.wr_data   (rf_wval),
		.clear     (commit && fault)
	);

	tcis_store #(.DEPTH(DATA_DEPTH)) u_data (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr   (in_dadr),
		.rd_data   (dm_rd_data),
		.chk_addr  (dadr_s1),
		.chk_valid (dm_chk_valid),
		.wr_en     (commit && dm_we),
		.wr_addr   (dm_adr),
		.wr_data   (reg_rd),
		.clear     (commit && fault)
	);

	// Pick forwarded or stored operands; unwritten entries read zero
	assign reg_rd = rfwd_s1 ? rfwd_val_s1 : (rf_chk_valid ? rf_rd_data : '0);
	assign dat_rd = dfwd_s1 ? dfwd_val_s1 : (dm_chk_valid ? dm_rd_data : '0);
	assign rf_dst = reg_map[op1_s1[REG_SEL_W-1:0]];
	assign dm_adr = addr_map[op1_s1];

	// Execute the instruction held in the stage
	always_comb begin
		res         = '0;
		res.next_pc = pc_q + 1'b1;
		rf_we       = 1'b0;
		rf_wval     = '0;
		dm_we       = 1'b0;
		fault       = 1'b0;
		case (opc_s1)
			OPC_NOP: begin
			end
			OPC_LDI: begin
				rf_we   = 1'b1;
				rf_wval = op2_s1;
			end
			OPC_MOV: begin
				rf_we   = 1'b1;
				rf_wval = reg_rd;
			end
			OPC_OUT: begin
				dm_we          = 1'b1;
				res.io_write   = 1'b1;
				res.io_address = BYTE_W'(dm_adr);
				res.io_data    = reg_rd;
			end
			OPC_IN: begin
				rf_we   = 1'b1;
				rf_wval = dat_rd;
			end
			OPC_JMP: begin
				res.next_pc = op1_s1;
			end
			default: begin
				fault           = 1'b1;
				res.next_pc     = '0;
				res.fault_reset = 1'b1;
			end
		endcase
		if (rf_we) begin
			res.reg_written = 1'b1;
			res.reg_index   = REG_SEL_W'(rf_dst);
			res.reg_value   = rf_wval;
		end
	end

	// Advance the execute stage, capture forwarding on overlapping writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (commit) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opc_s1      <= instr.data.instr_word[WORD_W-1:2*BYTE_W];
			op1_s1      <= instr.data.instr_word[2*BYTE_W-1:BYTE_W];
			op2_s1      <= in_op2;
			src_s1      <= in_src;
			dadr_s1     <= in_dadr;
			rfwd_s1     <= commit && rf_we && (rf_dst == in_src);
			rfwd_val_s1 <= rf_wval;
			dfwd_s1     <= commit && dm_we && (dm_adr == in_dadr);
			dfwd_val_s1 <= reg_rd;
		end
	end

	// Hold the result until transfer; update the program counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= '0;
			out_vld_q <= 1'b0;
		end else if (commit) begin
			pc_q      <= res.next_pc;
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_q <= res;
		end
	end

	assign result.valid = out_vld_q;
	assign result.data  = out_q;

	// A write back always leaves a result waiting
	a_commit_fills: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_vld_q)
		else $error("commit did not load output register");

	// A fault reports nothing else and restarts at address zero
	a_fault_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.fault_reset) |->
			(out_q.next_pc == '0 && !out_q.reg_written && !out_q.io_write))
		else $error("fault result carries other fields");

	// Register write and data write never come from one instruction
	a_write_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> !(out_q.reg_written && out_q.io_write))
		else $error("register and data write in one result");

	// The program counter follows the next_pc loaded into the output register
	a_pc_track: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (pc_q == out_q.next_pc))
		else $error("program counter out of step with result");

endmodule

`default_nettype wire

FILE: hdl/tcis_store.sv
// Byte store: synchronous memory with registered read and per-entry valid bits.
`default_nettype none

module tcis_store import tcis_pkg::*; #(
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [BYTE_W-1:0]        rd_data,
	input  wire logic [$clog2(DEPTH)-1:0] chk_addr,
	output logic                          chk_valid,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [BYTE_W-1:0]        wr_data,
	input  wire logic                     clear
);

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;
	logic [DEPTH-1:0]  valid_q;

	// Read and write the array, read data registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Track written entries; clear drops all of them at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data   = rd_data_q;
	assign chk_valid = valid_q[chk_addr];

endmodule

`default_nettype wire

FILE: verif/tb_tiny_cpu_instruction_step_top.sv
// Self-checking testbench for the tiny CPU instruction step block.
`timescale 1ns / 1ps

module tb_tiny_cpu_instruction_step_top;
	import tcis_pkg::*;

	localparam int unsigned CLK_HALF = 6;
	localparam int unsigned N_PROG   = 900;
	localparam int unsigned N_STREAM = 150;

	logic clk;
	logic arst_n;

	tcis_chan_if #(.payload_t(instr_t))  instr_ch ();
	tcis_chan_if #(.payload_t(result_t)) result_ch ();

	tiny_cpu_instruction_step_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_ch),
		.result (result_ch)
	);

	// Machine state mirrored by the predictor
	logic [BYTE_W-1:0] cpu_pc;
	logic [BYTE_W-1:0] cpu_regs [REG_SEL_N];
	logic [BYTE_W-1:0] io_mem [ADDR_N];
	logic              io_mem_valid [ADDR_N];

	result_t pending_results [$];
	bit      idle_en = 1'b1;
	int      n_fail;
	int      n_sent;
	int      n_checked;
	int      n_reg_wr;
	int      n_io_wr;
	int      n_fault;

	// Clock
	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// Give up after a generous bound
	initial begin
		#(5_000_000);
		$display("tiny_cpu_instruction_step_top regression: fail");
		$finish;
	end

	// Execute one instruction on the mirrored state and return its result
	function automatic result_t exec_instr(input logic [WORD_W-1:0] word);
		result_t           r;
		logic [BYTE_W-1:0] opc;
		logic [BYTE_W-1:0] op1;
		logic [BYTE_W-1:0] op2;
		r   = '0;
		opc = word[23:16];
		op1 = word[15:8];
		op2 = word[7:0];
		cpu_pc = cpu_pc + 8'd1;
		case (opc)
			OPC_NOP: ;
			OPC_LDI: begin
				r.reg_written = 1'b1;
				r.reg_index   = op1[REG_SEL_W-1:0];
				r.reg_value   = op2;
			end
			OPC_MOV: begin
				r.reg_written = 1'b1;
				r.reg_index   = op1[REG_SEL_W-1:0];
				r.reg_value   = cpu_regs[op2[REG_SEL_W-1:0]];
			end
			OPC_OUT: begin
				r.io_write   = 1'b1;
				r.io_address = op1;
				r.io_data    = cpu_regs[op2[REG_SEL_W-1:0]];
				io_mem[op1]       = r.io_data;
				io_mem_valid[op1] = 1'b1;
			end
			OPC_IN: begin
				r.reg_written = 1'b1;
				r.reg_index   = op1[REG_SEL_W-1:0];
				r.reg_value   = io_mem_valid[op2] ? io_mem[op2] : 8'd0;
			end
			OPC_JMP: cpu_pc = op1;
			default: begin
				cpu_pc = '0;
				foreach (cpu_regs[i]) cpu_regs[i] = '0;
				foreach (io_mem_valid[i]) io_mem_valid[i] = 1'b0;
				r.fault_reset = 1'b1;
			end
		endcase
		if (r.reg_written)
			cpu_regs[r.reg_index] = r.reg_value;
		r.next_pc = cpu_pc;
		return r;
	endfunction

	// Random instruction, mostly known opcodes, addresses biased to a few slots
	function automatic logic [WORD_W-1:0] rand_instr();
		logic [BYTE_W-1:0] opc;
		logic [BYTE_W-1:0] op1;
		logic [BYTE_W-1:0] op2;
		int                pick;
		pick = $urandom_range(0, 99);
		op1  = 8'($urandom);
		op2  = 8'($urandom);
		if (pick < 8)
			opc = OPC_NOP;
		else if (pick < 30)
			opc = OPC_LDI;
		else if (pick < 48)
			opc = OPC_MOV;
		else if (pick < 66) begin
			opc = OPC_OUT;
			if ($urandom_range(0, 1)) op1 = 8'($urandom_range(0, 7));
		end else if (pick < 84) begin
			opc = OPC_IN;
			if ($urandom_range(0, 1)) op2 = 8'($urandom_range(0, 7));
		end else if (pick < 94)
			opc = OPC_JMP;
		else begin
			do
				opc = 8'($urandom);
			while (opc <= OPC_IN || opc == OPC_JMP);
		end
		return {opc, op1, op2};
	endfunction

	// Drive one instruction, wait for its transfer, record the expected result
	task automatic send_instr(input logic [WORD_W-1:0] word);
		int gap;
		if (idle_en && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 14);
			instr_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		instr_ch.valid <= 1'b1;
		instr_ch.data  <= instr_t'(word);
		@(posedge clk);
		while (!instr_ch.ready) @(posedge clk);
		pending_results.push_back(exec_instr(word));
		n_sent++;
	endtask

	// Hold the sender until every outstanding result has arrived
	task automatic drain_results();
		instr_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			n_fail++;
		end
	endtask

	// Every opcode, field extremes, masking, pc wrap, unwritten reads, faults
	task automatic test_directed_ops();
		send_instr(24'h000000);
		send_instr(24'h011001);
		send_instr(24'h01FFFF);
		send_instr(24'h01E0AA);
		send_instr(24'h02011F);
		send_instr(24'h0202E0);
		send_instr(24'h030010);
		send_instr(24'h03FF1F);
		send_instr(24'h040200);
		send_instr(24'h041002);
		send_instr(24'h0403FF);
		send_instr(24'h04FF05);
		send_instr(24'h160500);
		send_instr(24'h16FF00);
		send_instr(24'h00FFFF);
		send_instr(24'h050000);
		send_instr(24'h020003);
		send_instr(24'h040300);
		send_instr(24'h01FF00);
		send_instr(24'hFFFFFF);
		send_instr(24'h150000);
		send_instr(24'h17ABCD);
		send_instr(24'h80FFFF);
	endtask

	// Rebuild state after a fault and read back across it
	task automatic test_fault_recovery();
		send_instr(24'h01055A);
		send_instr(24'h031005);
		send_instr(24'h800000);
		send_instr(24'h040610);
		send_instr(24'h020705);
		send_instr(24'h010933);
		send_instr(24'h020A09);
		send_instr(24'h03200A);
		send_instr(24'h040B20);
		send_instr(24'h031009);
		send_instr(24'h040C10);
	endtask

	// Short bursts with the sender held until the block is empty
	task automatic test_drain_pause();
		for (int round = 0; round < 4; round++) begin
			for (int i = 0; i < 25; i++)
				send_instr(rand_instr());
			drain_results();
		end
	endtask

	// Random programs fetched at the reported pc, with some raw noise words
	task automatic test_random_programs(input int n_items);
		logic [WORD_W-1:0] prog [ADDR_N];
		for (int i = 0; i < n_items; i++) begin
			if (i % 64 == 0)
				foreach (prog[a]) prog[a] = rand_instr();
			if ($urandom_range(0, 9) == 0)
				send_instr(24'($urandom));
			else
				send_instr(prog[cpu_pc]);
		end
	endtask

	// Back-to-back transfers on both sides, dependent chains included
	task automatic test_stream_no_idle(input int n_items);
		logic [BYTE_W-1:0] r;
		idle_en = 1'b0;
		for (int i = 0; i < n_items; i += 4) begin
			r = 8'($urandom);
			send_instr({OPC_LDI, r, 8'($urandom)});
			send_instr({OPC_MOV, 8'($urandom), r});
			send_instr({OPC_OUT, 8'(i), 8'($urandom)});
			send_instr({OPC_IN, 8'($urandom), 8'(i)});
		end
	endtask

	// Receiver stalls in random bursts while idling is on
	initial begin
		int stall;
		stall = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!idle_en)
				result_ch.ready <= 1'b1;
			else if (stall > 0) begin
				stall--;
				result_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 14) - 1;
				result_ch.ready <= 1'b0;
			end else
				result_ch.ready <= 1'b1;
		end
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		result_t exp_r;
		result_t got_r;
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready) begin
			got_r = result_ch.data;
			if (pending_results.size() == 0) begin
				$error("unexpected result transfer: 0x%0h", got_r);
				n_fail++;
			end else begin
				exp_r = pending_results.pop_front();
				check_field("next_pc", 32'(exp_r.next_pc), 32'(got_r.next_pc));
				check_field("reg_written", 32'(exp_r.reg_written),
					32'(got_r.reg_written));
				check_field("reg_index", 32'(exp_r.reg_index), 32'(got_r.reg_index));
				check_field("reg_value", 32'(exp_r.reg_value), 32'(got_r.reg_value));
				check_field("io_write", 32'(exp_r.io_write), 32'(got_r.io_write));
				check_field("io_address", 32'(exp_r.io_address),
					32'(got_r.io_address));
				check_field("io_data", 32'(exp_r.io_data), 32'(got_r.io_data));
				check_field("fault_reset", 32'(exp_r.fault_reset),
					32'(got_r.fault_reset));
				n_checked++;
				n_reg_wr += int'(exp_r.reg_written);
				n_io_wr  += int'(exp_r.io_write);
				n_fault  += int'(exp_r.fault_reset);
			end
		end
	end

	// Sequence: reset, tests in turn, drain, verdict
	initial begin
		arst_n         <= 1'b0;
		instr_ch.valid <= 1'b0;
		instr_ch.data  <= '0;
		cpu_pc = '0;
		foreach (cpu_regs[i]) cpu_regs[i] = '0;
		foreach (io_mem[i]) io_mem[i] = '0;
		foreach (io_mem_valid[i]) io_mem_valid[i] = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_ops();
		test_fault_recovery();
		test_drain_pause();
		test_random_programs(N_PROG);
		test_stream_no_idle(N_STREAM);

		drain_results();
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			n_fail++;
		end

		$display("Ran %0d instructions, %0d results checked: %0d register writes,",
			n_sent, n_checked, n_reg_wr);
		$display("%0d data memory writes, %0d fault resets, with and without stalls.",
			n_io_wr, n_fault);
		if (n_fail == 0)
			$display("tiny_cpu_instruction_step_top regression: pass");
		else
			$display("tiny_cpu_instruction_step_top regression: fail");
		$finish;
	end

endmodule
